>>> sv/bplm_pkg.sv
// ----------------------------------------------------------------------------
// bplm_pkg
// Shared types and codes for the buffer pool LRU manager.
// ----------------------------------------------------------------------------
package bplm_pkg;

    localparam int FRAMES_DEF   = 32;
    localparam int PIN_BITS_DEF = 16;

    localparam logic [1:0] FN_GET = 2'd0;
    localparam logic [1:0] FN_REL = 2'd1;
    localparam logic [1:0] FN_NEW = 2'd2;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_NOFRAME = 3'd2;
    localparam logic [2:0] ST_NEW     = 3'd3;
    localparam logic [2:0] ST_REL     = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    // write command broadcast to every cell
    typedef struct packed {
        logic we;
        logic move;
    } cell_ctrl_t;

    // compare results reported by one cell
    typedef struct packed {
        logic hit;
        logic empty;
        logic unpinned;
        logic id_match;
    } cell_flags_t;

endpackage

>>> sv/bplm_cell.sv
// ----------------------------------------------------------------------------
// bplm_cell
// One recency position: holds a frame id, its tag, pin count and dirty mark,
// compares tag and id against the request keys and shifts from its front neighbor.
// ----------------------------------------------------------------------------
module bplm_cell #(
    parameter int FRAMES   = bplm_pkg::FRAMES_DEF,
    parameter int PIN_BITS = bplm_pkg::PIN_BITS_DEF,
    parameter int IDX      = 0,
    parameter int IDW      = $clog2(FRAMES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bplm_pkg::cell_ctrl_t  ctrl,
    input  logic [IDW-1:0]        pos,
    input  logic [31:0]           key_tag,
    input  logic [IDW-1:0]        key_id,
    input  logic [IDW-1:0]        new_id,
    input  logic [31:0]           new_tag,
    input  logic [PIN_BITS-1:0]   new_pin,
    input  logic                  new_dirty,
    input  logic [IDW-1:0]        prev_id,
    input  logic [31:0]           prev_tag,
    input  logic [PIN_BITS-1:0]   prev_pin,
    input  logic                  prev_dirty,
    output logic [IDW-1:0]        id,
    output logic [31:0]           tag,
    output logic [PIN_BITS-1:0]   pin,
    output logic                  dirty,
    output bplm_pkg::cell_flags_t flags
);
    import bplm_pkg::*;

    localparam logic [IDW-1:0] MY_POS = IDW'(IDX);

    logic [IDW-1:0]      id_reg;
    logic [31:0]         tag_reg;
    logic [PIN_BITS-1:0] pin_reg;
    logic                dirty_reg;
    logic                load_new;
    logic                load_prev;

    always_comb
    begin
        load_new  = 1'b0;
        load_prev = 1'b0;
        if (ctrl.we)
        begin
            if (ctrl.move)
            begin
                load_new  = (MY_POS == '0);
                load_prev = (MY_POS != '0) && (MY_POS <= pos);
            end
            else
            begin
                load_new = (MY_POS == pos);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg    <= MY_POS;
            tag_reg   <= '0;
            pin_reg   <= '0;
            dirty_reg <= 1'b0;
        end
        else if (load_new)
        begin
            id_reg    <= new_id;
            tag_reg   <= new_tag;
            pin_reg   <= new_pin;
            dirty_reg <= new_dirty;
        end
        else if (load_prev)
        begin
            id_reg    <= prev_id;
            tag_reg   <= prev_tag;
            pin_reg   <= prev_pin;
            dirty_reg <= prev_dirty;
        end
    end

    assign id    = id_reg;
    assign tag   = tag_reg;
    assign pin   = pin_reg;
    assign dirty = dirty_reg;

    assign flags.hit      = (tag_reg == key_tag);
    assign flags.empty    = (tag_reg == '0);
    assign flags.unpinned = (pin_reg == '0);
    assign flags.id_match = (id_reg == key_id);

endmodule

>>> sv/buffer_pool_lru_manager_unit.sv
// ----------------------------------------------------------------------------
// buffer_pool_lru_manager_unit
// Pool of frames in recency order, held in a chain of cells; serves get,
// release and new requests and reports evictions and fills.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 contents
//  s_*       in   s_tvalid/s_tready         request item (tuser func)
//  m_*       out  m_tvalid/m_tready         result item (tuser status)
//  apb       in   psel/penable/pwrite       initial_block_count at 0x0
//
//  An item goes through accept, parallel compare in every cell, priority
//  pick of the position, then read of that cell and the shift of the chain.
//  No new item is accepted until the chain update of the last one is done.
//  Reset leaves every frame empty in index order; no clearing pass.
//  A stalled output holds the last step until the result register frees.
// ----------------------------------------------------------------------------
module buffer_pool_lru_manager_unit #(
    parameter int FRAMES   = bplm_pkg::FRAMES_DEF,
    parameter int PIN_BITS = bplm_pkg::PIN_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // block_number[31:0], frame[36:32], mark_dirty[37]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // frame_index[4:0], writeback_needed[5],
                                   // writeback_block[37:6], fill_needed[38],
                                   // granted_block[70:39]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bplm_pkg::*;

    localparam int IDW = $clog2(FRAMES);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_SEL   = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    localparam logic [2:0] A_HIT = 3'd0;
    localparam logic [2:0] A_REL = 3'd1;
    localparam logic [2:0] A_VIC = 3'd2;
    localparam logic [2:0] A_NOV = 3'd3;
    localparam logic [2:0] A_INV = 3'd4;

    function automatic logic [IDW-1:0] first_one(input logic [FRAMES-1:0] v);
        logic [IDW-1:0] r;
        r = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (v[i])
                r = IDW'(i);
        end
        return r;
    endfunction

    function automatic logic [IDW-1:0] last_one(input logic [FRAMES-1:0] v);
        logic [IDW-1:0] r;
        r = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (v[i])
                r = IDW'(i);
        end
        return r;
    endfunction

    logic [1:0]          state_reg, state_next;
    logic [1:0]          func_reg;
    logic [31:0]         bn_reg;
    logic [4:0]          fr_reg;
    logic                md_reg;
    logic [31:0]         init_count_reg;
    logic [31:0]         last_block_reg;
    logic [FRAMES-1:0]   hit_v_reg, empty_v_reg, unpin_v_reg, idm_v_reg;
    logic [IDW-1:0]      pos_reg;
    logic [2:0]          act_reg;
    logic                out_valid_reg;
    logic [2:0]          out_status_reg;
    logic [70:0]         out_data_reg;

    cell_ctrl_t          ctrl;
    cell_flags_t         flags [FRAMES];
    logic [IDW-1:0]      c_id  [FRAMES];
    logic [31:0]         c_tag [FRAMES];
    logic [PIN_BITS-1:0] c_pin [FRAMES];
    logic                c_dirty [FRAMES];
    logic [IDW-1:0]      key_id;
    logic [IDW-1:0]      new_id;
    logic [31:0]         new_tag;
    logic [PIN_BITS-1:0] new_pin;
    logic                new_dirty;
    logic [31:0]         fr_ext;
    logic                go;
    logic [2:0]          res_status;
    logic [4:0]          res_frame;
    logic                res_wb;
    logic [31:0]         res_wbb;
    logic                res_fill;
    logic [31:0]         res_gb;
    logic [IDW-1:0]      sel_id;
    logic [31:0]         sel_tag;
    logic [PIN_BITS-1:0] sel_pin;
    logic                sel_dirty;
    logic                cfg_wr;

    assign fr_ext = {27'd0, fr_reg};
    assign key_id = fr_ext[IDW-1:0];

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++)
        begin : g_cell
            localparam int PV = (g == 0) ? 0 : g - 1;
            bplm_cell #(
                .FRAMES(FRAMES), .PIN_BITS(PIN_BITS), .IDX(g), .IDW(IDW)
            ) u_cell (
                .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .pos(pos_reg),
                .key_tag(bn_reg), .key_id(key_id),
                .new_id(new_id), .new_tag(new_tag), .new_pin(new_pin),
                .new_dirty(new_dirty),
                .prev_id(c_id[PV]), .prev_tag(c_tag[PV]), .prev_pin(c_pin[PV]),
                .prev_dirty(c_dirty[PV]),
                .id(c_id[g]), .tag(c_tag[g]), .pin(c_pin[g]), .dirty(c_dirty[g]),
                .flags(flags[g])
            );
        end
    endgenerate

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == 3'd0);
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? init_count_reg : 32'd0;

    assign sel_id    = c_id[pos_reg];
    assign sel_tag   = c_tag[pos_reg];
    assign sel_pin   = c_pin[pos_reg];
    assign sel_dirty = c_dirty[pos_reg];

    assign go       = (state_reg == S_APPLY) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == S_IDLE);

    // work out the result and the record written back into the chain
    always_comb
    begin
        ctrl.we    = 1'b0;
        ctrl.move  = 1'b0;
        new_id     = sel_id;
        new_tag    = sel_tag;
        new_pin    = sel_pin;
        new_dirty  = sel_dirty;
        res_status = ST_INVALID;
        res_frame  = '0;
        res_wb     = 1'b0;
        res_wbb    = '0;
        res_fill   = 1'b0;
        res_gb     = '0;
        case (act_reg)
            A_HIT:
            begin
                if (sel_pin != PIN_MAX)
                begin
                    ctrl.we    = go;
                    ctrl.move  = 1'b1;
                    new_pin    = sel_pin + 1'b1;
                    res_status = ST_HIT;
                    res_frame  = 5'(32'(sel_id));
                    res_gb     = bn_reg;
                end
            end
            A_REL:
            begin
                if (sel_pin != '0)
                begin
                    ctrl.we    = go;
                    new_pin    = sel_pin - 1'b1;
                    new_dirty  = sel_dirty | md_reg;
                    res_status = ST_REL;
                    res_frame  = fr_reg;
                    res_gb     = sel_tag;
                end
            end
            A_VIC:
            begin
                ctrl.we    = go;
                ctrl.move  = 1'b1;
                new_tag    = (func_reg == FN_NEW) ? last_block_reg + 32'd1 : bn_reg;
                new_pin    = PIN_BITS'(1);
                new_dirty  = 1'b0;
                res_status = (func_reg == FN_NEW) ? ST_NEW : ST_MISS;
                res_frame  = 5'(32'(sel_id));
                res_wb     = sel_dirty;
                res_wbb    = sel_dirty ? sel_tag : 32'd0;
                res_fill   = (func_reg != FN_NEW);
                res_gb     = new_tag;
            end
            A_NOV:
            begin
                res_status = ST_NOFRAME;
            end
            default:
            begin
                res_status = ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_CMP;
            S_CMP:   state_next = S_SEL;
            S_SEL:   state_next = S_APPLY;
            S_APPLY: if (go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            init_count_reg <= '0;
            last_block_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                init_count_reg <= pwdata;
                last_block_reg <= pwdata;
            end
            else if (ctrl.we && (act_reg == A_VIC) && (func_reg == FN_NEW))
            begin
                last_block_reg <= last_block_reg + 32'd1;
            end
            if (go)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, compare, pick and result registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg <= s_tuser;
            bn_reg   <= s_tdata[31:0];
            fr_reg   <= s_tdata[36:32];
            md_reg   <= s_tdata[37];
        end
        if (state_reg == S_CMP)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                hit_v_reg[i]   <= flags[i].hit;
                empty_v_reg[i] <= flags[i].empty;
                unpin_v_reg[i] <= flags[i].unpinned;
                idm_v_reg[i]   <= flags[i].id_match;
            end
        end
        if (state_reg == S_SEL)
        begin
            pos_reg <= '0;
            act_reg <= A_INV;
            if (func_reg == FN_REL)
            begin
                if (fr_ext < 32'(FRAMES))
                begin
                    act_reg <= A_REL;
                    pos_reg <= first_one(idm_v_reg);
                end
            end
            else if ((func_reg == FN_GET && bn_reg != '0 && hit_v_reg != '0))
            begin
                act_reg <= A_HIT;
                pos_reg <= first_one(hit_v_reg);
            end
            else if ((func_reg == FN_GET && bn_reg != '0)
                     || (func_reg == FN_NEW && last_block_reg != 32'hFFFF_FFFF))
            begin
                // take the front empty frame, else the back unpinned one
                if (empty_v_reg != '0)
                begin
                    act_reg <= A_VIC;
                    pos_reg <= first_one(empty_v_reg);
                end
                else if (unpin_v_reg != '0)
                begin
                    act_reg <= A_VIC;
                    pos_reg <= last_one(unpin_v_reg);
                end
                else
                begin
                    act_reg <= A_NOV;
                end
            end
        end
        if (go)
        begin
            out_status_reg <= res_status;
            out_data_reg   <= {res_gb, res_fill, res_wbb, res_wb, res_frame};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE))
        else $error("input ready outside idle");
    a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_CMP))
        else $error("accepted item did not start compare");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_INVALID || m_tuser == ST_NOFRAME))
        |-> (m_tdata == '0))
        else $error("failed result carries data");
    a_write_apply: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.we |-> (state_reg == S_APPLY))
        else $error("chain written outside apply");

endmodule
